>>> rtl/memory_map_reserve_carver_top_assert.svh
// Assertion macros for the reserve carver top level.
// Each use expands to one labeled concurrent assertion on the block clock,
// held off while the asynchronous reset is asserted.
`ifndef MEMORY_MAP_RESERVE_CARVER_TOP_ASSERT_SVH
`define MEMORY_MAP_RESERVE_CARVER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMRC_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mmrc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mmrc: next-cycle check failed");

`endif

>>> rtl/mmrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmrc_pkg
// Shared constants and types of the memory map reserve carver: map geometry,
// command, status and register codes, and the map entry layout.
// ----------------------------------------------------------------------------
package mmrc_pkg;

	localparam int MAP_CAPACITY = 80;
	localparam int ADDR_W       = $clog2(MAP_CAPACITY);
	localparam int COUNT_W      = $clog2(MAP_CAPACITY + 1);

	// window end fits in base (20 bits) plus kb << 10 (21 bits)
	localparam int WIN_W    = 22;
	localparam int KB_SHIFT = 10;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_SOURCE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_PASSED   = 2'd3;

	localparam logic [1:0] CFG_BASE  = 2'd0;
	localparam logic [1:0] CFG_KB    = 2'd1;
	localparam logic [1:0] CFG_NEWER = 2'd2;

	localparam logic [31:0] TYPE_FREE     = 32'h1;
	localparam logic [31:0] TYPE_RESERVED = 32'h2;

	localparam logic [1:0] PASSES_TO_RELEASE = 2'd3;
	localparam logic [7:0] EXCESS_MAX        = 8'hFF;

	typedef struct packed {
		logic [31:0] etype;
		logic [63:0] ebase;
		logic [63:0] elen;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} ram_wr_t;

endpackage

>>> rtl/memory_map_reserve_carver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_reserve_carver_top
// Builds a memory map with a reserved window carved out of the free entries,
// then serves indexed queries on it.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (in_valid / in_stall) carries one command per transfer:
// clear, source entry or query. Every command gives exactly one result on the
// output channel (out_valid / out_stall). The user must write registers over
// the cfg channel (cfg_valid / cfg_ready, always ready) only while the block is
// idle; the block does not enforce it. One command at a time: in_stall is high
// from the accept until the result has moved into the output register.
// Steps from accept to next accept:
//   source entry    states S_PREP1 and S_PREP2, three write slots to the map RAM
//   query           map RAM read, read data registered
//   clear, other    direct (also a query once released, a source after overflow)
// The output register holds a result while out_stall is high; the next
// command is still taken and parks its result until the register frees.
// Reset clears map count, flags, pass counter and registers; map contents
// are left as they are and only read below the current count.
// ----------------------------------------------------------------------------
`include "memory_map_reserve_carver_top_assert.svh"

module memory_map_reserve_carver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] src_type,
	input  logic [63:0] src_base,
	input  logic [63:0] src_length,
	input  logic [31:0] query_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [6:0]  map_count,
	output logic [31:0] entry_type,
	output logic [63:0] entry_base,
	output logic [63:0] entry_length,
	output logic [6:0]  next_index,
	output logic        filter_released,
	output logic [7:0]  excess_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int CW = mmrc_pkg::COUNT_W;
	localparam int AW = mmrc_pkg::ADDR_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP1 = 3'd1;
	localparam logic [2:0] S_PREP2 = 3'd2;
	localparam logic [2:0] S_WR    = 3'd3;
	localparam logic [2:0] S_SFIN  = 3'd4;
	localparam logic [2:0] S_QRY   = 3'd5;
	localparam logic [2:0] S_QRD   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	localparam logic [1:0] SLOT_LOW  = 2'd0;
	localparam logic [1:0] SLOT_RES  = 2'd1;
	localparam logic [1:0] SLOT_HIGH = 2'd2;

	typedef struct packed {
		logic [1:0]       st;
		logic [CW-1:0]    count;
		mmrc_pkg::entry_t entry;
		logic [CW-1:0]    next;
		logic             released;
		logic [7:0]       excess;
	} res_t;

	// control state
	logic [2:0]    state_q;
	logic [1:0]    slot_q;
	logic [CW-1:0] fill_q;
	logic          rw_q;
	logic          ovf_q;
	logic [7:0]    excess_q;
	logic [1:0]    passes_q;
	logic          released_q;
	logic [19:0]   rbase_q;
	logic [10:0]   rkb_q;
	logic          newer_q;
	logic          out_valid_q;

	// payload
	logic [31:0]       type_q;
	logic [63:0]       base_q;
	logic [63:0]       len_q;
	logic [31:0]       idx_q;
	logic [63:0]       last_q;
	logic [mmrc_pkg::WIN_W-1:0] win_end_q;
	logic [2:0]        want_q;
	logic              ovl_q;
	logic              rng_q;
	res_t              res_q;
	res_t              out_q;

	// datapath
	logic [63:0]       win_start;
	logic [63:0]       win_len;
	logic [63:0]       win_end;
	logic [63:0]       win_last;
	logic [63:0]       lo;
	logic [63:0]       hi;
	logic              overlap;
	logic [2:0]        want_d;
	logic [CW-1:0]     vis_count;
	logic              full;
	logic              in_rng;
	logic [CW-1:0]     nx;
	logic [CW-1:0]     next_d;
	logic              complete;
	logic [1:0]        passes_nx;
	logic              released_nx;
	logic [7:0]        excess_inc;
	logic              out_free;
	res_t              res_d;

	mmrc_pkg::ram_wr_t ram_wr;
	logic              rd_en;
	mmrc_pkg::entry_t  rd_data;

	mmrc_map_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign win_start  = 64'(rbase_q);
	assign win_len    = 64'(rkb_q) << mmrc_pkg::KB_SHIFT;
	assign win_end    = 64'(win_end_q);
	assign win_last   = win_end - 64'd1;
	assign vis_count  = ovf_q ? '0 : fill_q;
	assign full       = (fill_q == CW'(mmrc_pkg::MAP_CAPACITY));
	assign in_rng     = (idx_q < 32'(vis_count));
	assign excess_inc = (excess_q == mmrc_pkg::EXCESS_MAX) ? excess_q : excess_q + 8'd1;

	// overlap and the write slots a source entry needs
	always_comb begin
		lo      = (win_start > base_q) ? win_start : base_q;
		hi      = (win_last < last_q) ? win_last : last_q;
		overlap = (type_q == mmrc_pkg::TYPE_FREE) && (rkb_q != '0) && (len_q != '0)
			&& (lo <= hi);
		if (overlap) begin
			want_d[SLOT_LOW]  = (base_q < win_start);
			want_d[SLOT_RES]  = !rw_q;
			want_d[SLOT_HIGH] = (win_end <= last_q);
		end else begin
			want_d[SLOT_LOW]  = 1'b0;
			want_d[SLOT_RES]  = !rw_q && (base_q > win_start);
			want_d[SLOT_HIGH] = 1'b1;
		end
	end

	// map write for the current slot
	always_comb begin
		ram_wr.en   = (state_q == S_WR) && want_q[slot_q] && !full;
		ram_wr.addr = fill_q[AW-1:0];
		case (slot_q)
			SLOT_LOW: begin
				ram_wr.data.etype = type_q;
				ram_wr.data.ebase = base_q;
				ram_wr.data.elen  = win_start - base_q;
			end
			SLOT_RES: begin
				ram_wr.data.etype = mmrc_pkg::TYPE_RESERVED;
				ram_wr.data.ebase = win_start;
				ram_wr.data.elen  = win_len;
			end
			default: begin
				if (ovl_q) begin
					ram_wr.data.etype = mmrc_pkg::TYPE_FREE;
					ram_wr.data.ebase = win_end;
					ram_wr.data.elen  = last_q - win_end + 64'd1;
				end else begin
					ram_wr.data.etype = type_q;
					ram_wr.data.ebase = base_q;
					ram_wr.data.elen  = len_q;
				end
			end
		endcase
	end

	assign rd_en = (state_q == S_QRY) && in_rng;

	// query continuation and pass counting
	always_comb begin
		nx          = CW'(idx_q[AW-1:0]) + CW'(1);
		next_d      = (rng_q && (nx < vis_count)) ? nx : '0;
		complete    = (next_d == '0) && !newer_q;
		passes_nx   = (complete && (passes_q < mmrc_pkg::PASSES_TO_RELEASE))
			? passes_q + 2'd1 : passes_q;
		released_nx = released_q
			|| (complete && (passes_nx >= mmrc_pkg::PASSES_TO_RELEASE));
	end

	// result for the state that finishes a command
	always_comb begin
		res_d          = '0;
		res_d.count    = vis_count;
		res_d.released = released_q;
		res_d.excess   = excess_q;
		case (state_q)
			S_IDLE: begin
				case (command)
					mmrc_pkg::CMD_CLEAR: begin
						res_d = '0;
					end
					mmrc_pkg::CMD_SOURCE: begin
						res_d.st     = mmrc_pkg::ST_OVERFLOW;
						res_d.excess = excess_inc;
					end
					mmrc_pkg::CMD_QUERY: begin
						res_d.st = mmrc_pkg::ST_PASSED;
					end
					default: begin
						res_d.st = mmrc_pkg::ST_OK;
					end
				endcase
			end
			S_SFIN: begin
				res_d.st = ovf_q ? mmrc_pkg::ST_OVERFLOW : mmrc_pkg::ST_OK;
			end
			S_QRD: begin
				res_d.st       = rng_q ? mmrc_pkg::ST_OK : mmrc_pkg::ST_RANGE;
				res_d.entry    = rng_q ? rd_data : '0;
				res_d.next     = next_d;
				res_d.released = released_nx;
			end
			default: begin
				res_d.st = mmrc_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= SLOT_LOW;
			fill_q      <= '0;
			rw_q        <= 1'b0;
			ovf_q       <= 1'b0;
			excess_q    <= '0;
			passes_q    <= '0;
			released_q  <= 1'b0;
			rbase_q     <= '0;
			rkb_q       <= '0;
			newer_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mmrc_pkg::CFG_BASE:  rbase_q <= cfg_data;
					mmrc_pkg::CFG_KB:    rkb_q   <= cfg_data[10:0];
					mmrc_pkg::CFG_NEWER: newer_q <= cfg_data[0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (command)
							mmrc_pkg::CMD_CLEAR: begin
								fill_q     <= '0;
								rw_q       <= 1'b0;
								ovf_q      <= 1'b0;
								excess_q   <= '0;
								passes_q   <= '0;
								released_q <= 1'b0;
								state_q    <= S_DONE;
							end
							mmrc_pkg::CMD_SOURCE: begin
								if (ovf_q) begin
									excess_q <= excess_inc;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_PREP1;
								end
							end
							mmrc_pkg::CMD_QUERY: begin
								state_q <= released_q ? S_DONE : S_QRY;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: begin
					slot_q  <= SLOT_LOW;
					state_q <= S_WR;
				end
				S_WR: begin
					if (want_q[slot_q] && full) begin
						// drop the rest of this entry
						ovf_q   <= 1'b1;
						state_q <= S_SFIN;
					end else begin
						if (want_q[slot_q]) begin
							fill_q <= fill_q + CW'(1);
							if (slot_q == SLOT_RES) begin
								rw_q <= 1'b1;
							end
						end
						if (slot_q == SLOT_HIGH) begin
							state_q <= S_SFIN;
						end else begin
							slot_q <= slot_q + 2'd1;
						end
					end
				end
				S_SFIN: state_q <= S_DONE;
				S_QRY:  state_q <= S_QRD;
				S_QRD: begin
					passes_q   <= passes_nx;
					released_q <= released_nx;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			type_q <= src_type;
			base_q <= src_base;
			len_q  <= src_length;
			idx_q  <= query_index;
		end
		if (state_q == S_PREP1) begin
			last_q    <= base_q + len_q - 64'd1;
			win_end_q <= mmrc_pkg::WIN_W'(rbase_q)
				+ (mmrc_pkg::WIN_W'(rkb_q) << mmrc_pkg::KB_SHIFT);
		end
		if (state_q == S_PREP2) begin
			want_q <= want_d;
			ovl_q  <= overlap;
		end
		if (state_q == S_QRY) begin
			rng_q <= in_rng;
		end
		// hold the finished result while it waits for the output register
		if (state_q != S_DONE) begin
			res_q <= res_d;
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.st;
	assign map_count       = 7'(out_q.count);
	assign entry_type      = out_q.entry.etype;
	assign entry_base      = out_q.entry.ebase;
	assign entry_length    = out_q.entry.elen;
	assign next_index      = 7'(out_q.next);
	assign filter_released = out_q.released;
	assign excess_count    = out_q.excess;

	`MMRC_ASSERT_HOLDS(a_wr_in_capacity, clk, arst_n, ram_wr.en, (fill_q < CW'(mmrc_pkg::MAP_CAPACITY)) && !ovf_q)
	`MMRC_ASSERT_HOLDS(a_release_after_passes, clk, arst_n, released_q, passes_q == mmrc_pkg::PASSES_TO_RELEASE)
	`MMRC_ASSERT_NEXT(a_result_lands, clk, arst_n, (state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE))

endmodule

>>> rtl/mmrc_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmrc_map_ram
// Map entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mmrc_map_ram (
	input  logic                        clk,
	input  mmrc_pkg::ram_wr_t           wr,
	input  logic                        rd_en,
	input  logic [mmrc_pkg::ADDR_W-1:0] rd_addr,
	output mmrc_pkg::entry_t            rd_data
);

	mmrc_pkg::entry_t mem [mmrc_pkg::MAP_CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> test/memory_map_reserve_carver_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_reserve_carver_top_test
// Self-checking bench for the reserve carver. Commands come from a queue fed
// by the sequence below. Each accepted command updates an in-bench copy of the
// map and the pass counter, and queues the result it should give. The result
// side is compared field by field in order. Both channels idle in random
// bursts; one phase holds the result side off long enough to back the block up.
// ----------------------------------------------------------------------------
module memory_map_reserve_carver_top_test;

	localparam logic [1:0]  CMD_SPARE   = 2'd3;
	localparam logic [31:0] TYPE_ACPI   = 32'h3;
	localparam logic [31:0] TYPE_NVS    = 32'h4;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          TAIL_CYCLES = 30;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] stype;
		logic [63:0] sbase;
		logic [63:0] slen;
		logic [31:0] qidx;
	} map_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  count;
		logic [31:0] etype;
		logic [63:0] ebase;
		logic [63:0] elen;
		logic [6:0]  next;
		logic        released;
		logic [7:0]  excess;
	} map_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [31:0] src_type = '0;
	logic [63:0] src_base = '0;
	logic [63:0] src_length = '0;
	logic [31:0] query_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [6:0]  map_count;
	logic [31:0] entry_type;
	logic [63:0] entry_base;
	logic [63:0] entry_length;
	logic [6:0]  next_index;
	logic        filter_released;
	logic [7:0]  excess_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	// window registers and map state as the block should hold them
	logic [19:0] win_base = '0;
	logic [10:0] win_kb = '0;
	logic        newer_q = 1'b0;
	logic [31:0] map_type [mmrc_pkg::MAP_CAPACITY];
	logic [63:0] map_base [mmrc_pkg::MAP_CAPACITY];
	logic [63:0] map_len [mmrc_pkg::MAP_CAPACITY];
	int          map_fill = 0;
	logic        resv_done = 1'b0;
	logic        map_ovf = 1'b0;
	logic [7:0]  map_excess = '0;
	logic [1:0]  map_passes = '0;
	logic        map_rel = 1'b0;

	map_cmd_t   cmd_queue[$];
	map_reply_t reply_queue[$];

	bit cmd_fire = 1'b0;
	bit send_idle_on = 1'b1;
	bit recv_idle_on = 1'b1;
	bit hold_req = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	memory_map_reserve_carver_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.src_type        (src_type),
		.src_base        (src_base),
		.src_length      (src_length),
		.query_index     (query_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.map_count       (map_count),
		.entry_type      (entry_type),
		.entry_base      (entry_base),
		.entry_length    (entry_length),
		.next_index      (next_index),
		.filter_released (filter_released),
		.excess_count    (excess_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit map_put(logic [31:0] t, logic [63:0] b, logic [63:0] l);
		if (map_ovf)
			return 1'b0;
		if (map_fill >= mmrc_pkg::MAP_CAPACITY) begin
			map_ovf = 1'b1;
			return 1'b0;
		end
		map_type[map_fill] = t;
		map_base[map_fill] = b;
		map_len[map_fill] = l;
		map_fill++;
		return 1'b1;
	endfunction

	function automatic bit put_window();
		if (!map_put(mmrc_pkg::TYPE_RESERVED, {44'd0, win_base}, {43'd0, win_kb, 10'd0}))
			return 1'b0;
		resv_done = 1'b1;
		return 1'b1;
	endfunction

	function automatic void carve_source(logic [31:0] t, logic [63:0] b, logic [63:0] l);
		logic [63:0] ws, wl, we, last, lo, hi, wlast;
		bit overlap;
		ws = {44'd0, win_base};
		wl = {43'd0, win_kb, 10'd0};
		we = ws + wl;
		last = b + l - 64'd1;
		overlap = 1'b0;
		// an entry whose end wraps past the top of the address space never overlaps
		if (t == mmrc_pkg::TYPE_FREE && wl != '0 && l != '0) begin
			lo = (ws > b) ? ws : b;
			wlast = we - 64'd1;
			hi = (wlast < last) ? wlast : last;
			overlap = (lo <= hi);
		end
		if (overlap) begin
			if (b < ws) begin
				if (!map_put(t, b, ws - b))
					return;
			end
			if (!resv_done) begin
				if (!put_window())
					return;
			end
			if (we <= last)
				void'(map_put(mmrc_pkg::TYPE_FREE, we, last - we + 64'd1));
		end else begin
			if (!resv_done && b > ws) begin
				if (!put_window())
					return;
			end
			void'(map_put(t, b, l));
		end
	endfunction

	function automatic map_reply_t predict_reply(map_cmd_t c);
		map_reply_t r;
		int unsigned cnt;
		int unsigned nxt;
		r = '0;
		nxt = 0;
		case (c.cmd)
		mmrc_pkg::CMD_CLEAR: begin
			map_fill = 0;
			resv_done = 1'b0;
			map_ovf = 1'b0;
			map_excess = '0;
			map_passes = '0;
			map_rel = 1'b0;
		end
		mmrc_pkg::CMD_SOURCE: begin
			if (map_ovf) begin
				if (map_excess != mmrc_pkg::EXCESS_MAX)
					map_excess++;
			end else begin
				carve_source(c.stype, c.sbase, c.slen);
			end
			r.status = map_ovf ? mmrc_pkg::ST_OVERFLOW : mmrc_pkg::ST_OK;
		end
		mmrc_pkg::CMD_QUERY: begin
			if (map_rel) begin
				r.status = mmrc_pkg::ST_PASSED;
			end else begin
				cnt = map_ovf ? 0 : map_fill;
				if (c.qidx >= cnt) begin
					r.status = mmrc_pkg::ST_RANGE;
				end else begin
					r.etype = map_type[c.qidx];
					r.ebase = map_base[c.qidx];
					r.elen = map_len[c.qidx];
					nxt = c.qidx + 32'd1;
					if (nxt >= cnt)
						nxt = 0;
				end
				// end of map and a bad index both close a pass, unless newer is set
				if (nxt == 0 && !newer_q) begin
					if (map_passes < mmrc_pkg::PASSES_TO_RELEASE)
						map_passes++;
					if (map_passes >= mmrc_pkg::PASSES_TO_RELEASE)
						map_rel = 1'b1;
				end
			end
		end
		default: ;
		endcase
		r.count = map_ovf ? 7'd0 : map_fill[6:0];
		r.next = nxt[6:0];
		r.released = map_rel;
		r.excess = map_excess;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("memory_map_reserve_carver_top regression: fail");
			$finish;
		end
	end

	// accept side: predict on each command transfer, compare on each result transfer
	always @(posedge clk) begin : watch_ports
		map_cmd_t   c;
		map_reply_t want;
		cmd_fire = arst_n && in_valid && !in_stall;
		if (cmd_fire) begin
			c.cmd = command;
			c.stype = src_type;
			c.sbase = src_base;
			c.slen = src_length;
			c.qidx = query_index;
			reply_queue.push_back(predict_reply(c));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (reply_queue.size() == 0) begin
				$error("result transfer with no command outstanding");
				mismatches++;
			end else begin
				want = reply_queue.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("map_count", 64'(want.count), 64'(map_count));
				check_field("entry_type", 64'(want.etype), 64'(entry_type));
				check_field("entry_base", want.ebase, entry_base);
				check_field("entry_length", want.elen, entry_length);
				check_field("next_index", 64'(want.next), 64'(next_index));
				check_field("filter_released", 64'(want.released),
					64'(filter_released));
				check_field("excess_count", 64'(want.excess), 64'(excess_count));
			end
		end
	end

	always @(negedge clk) begin : drive_cmds
		map_cmd_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || cmd_fire) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0 && send_idle_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 12);
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				c = cmd_queue.pop_front();
				in_valid <= 1'b1;
				command <= c.cmd;
				src_type <= c.stype;
				src_base <= c.sbase;
				src_length <= c.slen;
				query_index <= c.qidx;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
			recv_gap = $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic add_cmd(logic [1:0] cmd, logic [31:0] t, logic [63:0] b, logic [63:0] l,
			logic [31:0] q);
		map_cmd_t c;
		c.cmd = cmd;
		c.stype = t;
		c.sbase = b;
		c.slen = l;
		c.qidx = q;
		cmd_queue.push_back(c);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		mmrc_pkg::CFG_BASE:  win_base = val;
		mmrc_pkg::CFG_KB:    win_kb = val[10:0];
		mmrc_pkg::CFG_NEWER: newer_q = val[0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every queued command has been taken and answered
	task automatic drain();
		@(posedge clk);
		while (cmd_queue.size() != 0 || in_valid || reply_queue.size() != 0)
			@(posedge clk);
	endtask

	// clear, then a mostly ascending run of entries starting a little below the window
	task automatic build_map(int n);
		logic [63:0] at, off, len, b;
		logic [31:0] t;
		add_cmd(mmrc_pkg::CMD_CLEAR, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
			$urandom);
		off = 64'($urandom_range(0, 'h60000));
		at = {44'd0, win_base};
		if (at > off)
			at -= off;
		else
			at = '0;
		repeat (n) begin
			case ($urandom_range(0, 9))
			7:       t = mmrc_pkg::TYPE_RESERVED;
			8:       t = ($urandom_range(0, 1) != 0) ? TYPE_ACPI : TYPE_NVS;
			9:       t = $urandom;
			default: t = mmrc_pkg::TYPE_FREE;
			endcase
			case ($urandom_range(0, 9))
			6, 7:    len = 64'($urandom_range(0, 'h3FFFF));
			8:       len = '0;
			9:       len = {$urandom, $urandom};
			default: len = 64'($urandom_range(1, 48)) << 12;
			endcase
			b = ($urandom_range(0, 11) == 0) ? {$urandom, $urandom} : at;
			add_cmd(mmrc_pkg::CMD_SOURCE, t, b, len, $urandom);
			at = at + len + (64'($urandom_range(0, 3)) << 12);
		end
	endtask

	// walk the map as firmware would, with a stray query now and then
	task automatic walk_map();
		int cnt, i, passes;
		cnt = map_ovf ? 0 : map_fill;
		passes = (cnt > 20) ? 1 : $urandom_range(1, 2);
		repeat (passes) begin
			for (i = 0; i < cnt; i++)
				add_cmd(mmrc_pkg::CMD_QUERY, $urandom, {$urandom, $urandom},
					{$urandom, $urandom}, 32'(i));
			case ($urandom_range(0, 3))
			0: add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, $urandom);
			1: add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'(cnt));
			2: add_cmd(CMD_SPARE, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
					$urandom);
			default: ;
			endcase
		end
	endtask

	initial begin : sequence_run
		int ph;
		logic [19:0] base_v;
		logic [19:0] kb_v;
		logic [19:0] newer_v;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: 4 KB window just below the legacy video hole
		set_reg(mmrc_pkg::CFG_BASE, 20'h9F000);
		set_reg(mmrc_pkg::CFG_KB, 20'd4);
		set_reg(mmrc_pkg::CFG_NEWER, 20'd0);
		add_cmd(mmrc_pkg::CMD_CLEAR, '0, '0, '0, '0);
		add_cmd(mmrc_pkg::CMD_SOURCE, mmrc_pkg::TYPE_FREE, 64'h0, 64'h10_0000, '0);
		add_cmd(mmrc_pkg::CMD_SOURCE, mmrc_pkg::TYPE_RESERVED, 64'hF000_0000, 64'h1000, '0);
		add_cmd(mmrc_pkg::CMD_SOURCE, mmrc_pkg::TYPE_FREE, 64'hFFFF_FFFF_FFFF_F000,
			64'h2000, '0);
		add_cmd(mmrc_pkg::CMD_SOURCE, '1, '1, '1, '1);
		add_cmd(mmrc_pkg::CMD_SOURCE, mmrc_pkg::TYPE_FREE, 64'h9_F800, 64'h0, '0);
		add_cmd(CMD_SPARE, '1, '1, '1, '1);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd0);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd5);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd6);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, '1);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd7);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd0);
		add_cmd(mmrc_pkg::CMD_CLEAR, '0, '0, '0, '0);
		add_cmd(mmrc_pkg::CMD_SOURCE, mmrc_pkg::TYPE_RESERVED, 64'h0, 64'h1000, '0);
		add_cmd(mmrc_pkg::CMD_SOURCE, TYPE_ACPI, 64'h20_0000, 64'h1000, '0);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd0);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd1);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd2);
		add_cmd(mmrc_pkg::CMD_SOURCE, mmrc_pkg::TYPE_FREE, 64'h9_F000, 64'h1000, '0);
		add_cmd(mmrc_pkg::CMD_QUERY, '0, '0, '0, 32'd3);
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
			0: begin
				base_v = '0;
				kb_v = '0;
				newer_v = '0;
			end
			1: begin
				base_v = 20'hFFFFF;
				kb_v = 20'd1024;
				newer_v = '0;
			end
			2: begin
				base_v = '0;
				kb_v = 20'd1024;
				newer_v = 20'd1;
			end
			3: begin
				base_v = 20'hFFFFF;
				kb_v = '0;
				newer_v = 20'd1;
			end
			default: begin
				base_v = 20'($urandom);
				kb_v = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 1024))
					: 20'($urandom_range(1, 64));
				newer_v = 20'($urandom_range(0, 1));
			end
			endcase
			set_reg(mmrc_pkg::CFG_BASE, base_v);
			set_reg(mmrc_pkg::CFG_KB, kb_v);
			set_reg(mmrc_pkg::CFG_NEWER, newer_v);
			send_idle_on = (ph != 7) && ($urandom_range(0, 3) != 0);
			recv_idle_on = (ph != 7) && ($urandom_range(0, 3) != 0);

			if (ph == 2) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			repeat (2) begin
				build_map($urandom_range(1, 6));
				drain();
				walk_map();
				drain();
			end
			if (ph == 4) begin
				// run right up to the map capacity, then flood past it
				build_map($urandom_range(76, 84));
				drain();
				walk_map();
				drain();
				build_map(90);
				drain();
				walk_map();
				drain();
			end
		end

		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("memory_map_reserve_carver_top regression: pass");
		else
			$display("memory_map_reserve_carver_top regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mmrc_pkg.sv
rtl/mmrc_map_ram.sv
rtl/memory_map_reserve_carver_top.sv
test/memory_map_reserve_carver_top_test.sv
